>>> hdl/winograd_f2x2_3x3_tile_transform_core_macros.svh
// ----------------------------------------------------------------------------
// Winograd tile transform assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef WINOGRAD_F2X2_3X3_TILE_TRANSFORM_CORE_MACROS_SVH
`define WINOGRAD_F2X2_3X3_TILE_TRANSFORM_CORE_MACROS_SVH

// next-cycle implication, masked while reset is high
`define WTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, checked through reset as well
`define WTT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/wtt_pkg.sv
// ----------------------------------------------------------------------------
// Winograd tile transform package
// Result widths, mode codes, row counts and shared types.
// ----------------------------------------------------------------------------
package wtt_pkg;

   localparam int OUT_WIDTH   = 28;
   localparam int ROW_ELEMS   = 4;
   localparam int RSP_TDATA_W = ((ROW_ELEMS * OUT_WIDTH + 7) / 8) * 8;
   localparam int CNT_W       = 3;

   // transform_mode codes
   localparam logic MODE_INPUT  = 1'b0;
   localparam logic MODE_OUTPUT = 1'b1;

   // index of the row that completes a tile
   localparam logic [1:0] ROW_LAST = 2'd3;

   // result rows per tile
   localparam logic [CNT_W-1:0] ROWS_INPUT  = 3'd4;
   localparam logic [CNT_W-1:0] ROWS_OUTPUT = 3'd2;

   // one result row, column 0 in the low bits
   typedef logic [ROW_ELEMS-1:0][OUT_WIDTH-1:0] out_row_type;

   typedef struct packed {
      logic             load;
      logic [CNT_W-1:0] count;
   } bank_ctrl_type;

   typedef struct packed {
      logic free;
   } bank_status_type;

endpackage

>>> hdl/wtt_transform.sv
// ----------------------------------------------------------------------------
// Winograd tile transform datapath
// Two add/sub passes (columns, then rows) over one 4x4 tile, with saturation.
// ----------------------------------------------------------------------------
module wtt_transform #(
   parameter int DATA_WIDTH = 24
) (
   input  logic [3:0][3:0][DATA_WIDTH-1:0] tile,
   input  logic                            mode,
   output wtt_pkg::out_row_type [3:0]      rows
);
   import wtt_pkg::*;

   localparam int AW = DATA_WIDTH + 2;
   localparam int BW = DATA_WIDTH + 4;
   localparam int MW = (BW > OUT_WIDTH) ? BW : OUT_WIDTH;
   localparam logic signed [MW-1:0] SAT_HI = MW'((2 ** (OUT_WIDTH - 1)) - 1);
   localparam logic signed [MW-1:0] SAT_LO = -SAT_HI - MW'(1);

   // clamp a row sum into the result range
   function automatic logic [OUT_WIDTH-1:0] sat(input logic signed [BW-1:0] v);
      logic signed [MW-1:0] e;
      e = MW'(v);
      if (e > SAT_HI) begin
         e = SAT_HI;
      end else if (e < SAT_LO) begin
         e = SAT_LO;
      end
      return OUT_WIDTH'(e);
   endfunction

   logic signed [AW-1:0] x [4][4];
   logic signed [AW-1:0] a [4][4];
   logic signed [BW-1:0] y [4][4];

   // column pass: combine rows
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            x[r][c] = AW'($signed(tile[r][c]));
         end
      end
      for (int c = 0; c < 4; c++) begin
         if (mode == MODE_OUTPUT) begin
            a[0][c] = x[0][c] + x[1][c] + x[2][c];
            a[1][c] = x[1][c] - x[2][c] - x[3][c];
            a[2][c] = '0;
            a[3][c] = '0;
         end else begin
            a[0][c] = x[0][c] - x[2][c];
            a[1][c] = x[1][c] + x[2][c];
            a[2][c] = x[2][c] - x[1][c];
            a[3][c] = x[1][c] - x[3][c];
         end
      end
   end

   // row pass: combine columns, then saturate
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            y[r][c] = BW'(a[r][c]);
         end
         if (mode == MODE_OUTPUT) begin
            rows[r][0] = sat(y[r][0] + y[r][1] + y[r][2]);
            rows[r][1] = sat(y[r][1] - y[r][2] - y[r][3]);
            rows[r][2] = '0;
            rows[r][3] = '0;
         end else begin
            rows[r][0] = sat(y[r][0] - y[r][2]);
            rows[r][1] = sat(y[r][1] + y[r][2]);
            rows[r][2] = sat(y[r][2] - y[r][1]);
            rows[r][3] = sat(y[r][1] - y[r][3]);
         end
      end
   end

endmodule

>>> hdl/wtt_result_bank.sv
// ----------------------------------------------------------------------------
// Winograd tile transform result bank
// Holds the result rows of one tile and shifts them out one per response.
// ----------------------------------------------------------------------------
module wtt_result_bank (
   input  logic                         clock,
   input  logic                         reset,
   input  wtt_pkg::bank_ctrl_type       ctrl,
   input  wtt_pkg::out_row_type [3:0]   rows,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic                         rsp_last,
   output wtt_pkg::out_row_type         rsp_row,
   output wtt_pkg::bank_status_type     status
);
   import wtt_pkg::*;

   out_row_type [3:0] bank_ff, bank_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              take;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_last  = (cnt_ff == CNT_W'(1));
   assign rsp_row   = bank_ff[0];
   assign take      = rsp_valid && rsp_ready;

   // free when empty, or when the final row leaves this cycle
   assign status.free = (cnt_ff == '0) || (rsp_last && rsp_ready);

   // load a whole tile, or shift one row out
   always_comb begin
      bank_in = bank_ff;
      cnt_in  = cnt_ff;
      if (ctrl.load) begin
         bank_in = rows;
         cnt_in  = ctrl.count;
      end else if (take) begin
         for (int i = 0; i < 3; i++) begin
            bank_in[i] = bank_ff[i+1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff <= bank_in;
   end

endmodule

>>> hdl/winograd_f2x2_3x3_tile_transform_core.sv
// ----------------------------------------------------------------------------
// Winograd F(2x2,3x3) tile transform core
// Row-streamed B^T x B (input mode) or A^T m A (output mode) on 4x4 tiles.
// ----------------------------------------------------------------------------
// A tile arrives as four row requests: each row goes into an input register,
// rows 0 to 2 move into the tile store, and row 3 drives the transform logic,
// whose rows load a result bank when row 3 moves on. Results leave one row
// per cycle while rsp_tready is high, four in input mode and two in output
// mode, with tlast on the final row; the first result row reaches the
// response port through the input register and then the result bank
// register. The result bank alone sets the sustained rate: row 3 of a tile
// waits in the input register until the previous tile's final result row
// is taken, so with rsp_tready held high the core runs at one request per
// cycle.
module winograd_f2x2_3x3_tile_transform_core #(
   parameter int DATA_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration: transform_mode
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_data,
   // request: elem0, elem1, elem2, elem3 (DATA_WIDTH bits each, signed)
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]     req_tdata,
   // response: out0, out1, out2, out3 (28 bits each, signed)
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [wtt_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast
);
   import wtt_pkg::*;

   logic                           mode_ff, mode_in;
   logic [1:0]                     row_cnt_ff, row_cnt_in;
   logic                           in_vld_ff, in_vld_in;
   logic [1:0]                     in_idx_ff;
   logic [3:0][DATA_WIDTH-1:0]     in_row_ff;
   logic [2:0][3:0][DATA_WIDTH-1:0] tile_ff;
   logic [3:0][3:0][DATA_WIDTH-1:0] tile_all;
   logic                           req_acc;
   logic                           advance;
   out_row_type [3:0]              xf_rows;
   out_row_type                    rsp_row;
   bank_ctrl_type                  bank_ctrl;
   bank_status_type                bank_status;

   // configuration register
   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? csr_data : mode_ff;

   // input register moves on unless row 3 finds the bank busy
   assign advance    = in_vld_ff && ((in_idx_ff != ROW_LAST) || bank_status.free);
   assign req_tready = !in_vld_ff || advance;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      row_cnt_in = row_cnt_ff;
      in_vld_in  = in_vld_ff;
      if (req_acc) begin
         row_cnt_in = row_cnt_ff + 2'd1;
         in_vld_in  = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_INPUT;
         row_cnt_ff <= '0;
         in_vld_ff  <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         row_cnt_ff <= row_cnt_in;
         in_vld_ff  <= in_vld_in;
      end
   end

   // row payload and tile store
   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_idx_ff <= row_cnt_ff;
         for (int c = 0; c < 4; c++) begin
            in_row_ff[c] <= req_tdata[c*DATA_WIDTH +: DATA_WIDTH];
         end
      end
      if (advance && (in_idx_ff != ROW_LAST)) begin
         tile_ff[in_idx_ff] <= in_row_ff;
      end
   end

   assign tile_all = {in_row_ff, tile_ff};

   wtt_transform #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_transform (
      .tile (tile_all),
      .mode (mode_ff),
      .rows (xf_rows)
   );

   // load the bank when the completing row moves on
   assign bank_ctrl.load  = advance && (in_idx_ff == ROW_LAST);
   assign bank_ctrl.count = (mode_ff == MODE_OUTPUT) ? ROWS_OUTPUT : ROWS_INPUT;

   wtt_result_bank u_bank (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (bank_ctrl),
      .rows      (xf_rows),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_last  (rsp_tlast),
      .rsp_row   (rsp_row),
      .status    (bank_status)
   );

   assign rsp_tdata = RSP_TDATA_W'(rsp_row);

endmodule

>>> hdl/wtt_checker.sv
// ----------------------------------------------------------------------------
// Winograd tile transform port checker
// Port-level properties of the response stream, bound to the core.
// ----------------------------------------------------------------------------
`include "winograd_f2x2_3x3_tile_transform_core_macros.svh"

module wtt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [wtt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import wtt_pkg::*;

   // reset leaves no response pending and the request side open
   `WTT_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid && req_tready, "core not idle after reset")

   // a stalled response holds
   `WTT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled response changed")

   // rows of one tile come out without gaps
   `WTT_ASSERT_NEXT(a_tile_burst, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid, "gap inside a tile's result rows")

endmodule

bind winograd_f2x2_3x3_tile_transform_core wtt_checker u_wtt_checker (.*);
